>>> src/hcrr_pkg.sv
// ----------------------------------------------------------------------------
// hcrr_pkg
// Shared constants and control types for the hashed counter random range block.
// ----------------------------------------------------------------------------
package hcrr_pkg;

	localparam int WORD_W   = 64;
	localparam int FACTOR_W = 32;
	localparam int DIGIT_W  = 8;
	localparam int DIGITS   = FACTOR_W / DIGIT_W;
	localparam int DCNT_W   = $clog2(DIGITS);
	localparam int BCNT_W   = $clog2(WORD_W);
	localparam int SHIFT    = 32;

	localparam logic [WORD_W-1:0]   STEP_INCREMENT = 64'h0000_0000_E120_FC15;
	localparam logic [FACTOR_W-1:0] MIX_FACTOR_A   = 32'h4A39_B70D;
	localparam logic [FACTOR_W-1:0] MIX_FACTOR_B   = 32'h12FA_D5C9;

	// Start request to the shared multiply-and-fold unit
	typedef struct packed {
		logic start;
		logic sel_b;
	} fold_ctl_t;

	// Start request to the serial remainder unit
	typedef struct packed {
		logic start;
	} rem_ctl_t;

endpackage

>>> src/hashed_counter_random_range.sv
// An item whose bounds differ runs the two 4-digit serial multiplies and the
// 64-step serial remainder in turn; equal bounds give zero, skip straight to
// the done state and leave the counter as it is. A stalled output holds the
// done state. One item in flight at a time.
// Reset: arst_n clears the counter to zero and empties the block.
// ----------------------------------------------------------------------------
// hashed_counter_random_range
// Counter-based random number in a requested range: advance a 64-bit counter,
// mix it with two multiply-and-fold passes, reduce into the range.
// ----------------------------------------------------------------------------
module hashed_counter_random_range (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               seed_we,
	input  logic signed [31:0] seed_value,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [63:0] low_bound,
	input  logic signed [63:0] high_bound,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] random_value
);
	import hcrr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MIX_A,
		S_MIX_B,
		S_REDUCE,
		S_DONE
	} state_t;

	state_t            state_q;
	fold_ctl_t         fold_ctl_q;
	rem_ctl_t          rem_ctl_q;
	logic [WORD_W-1:0] counter_q;
	logic [WORD_W-1:0] lo_q;
	logic [WORD_W-1:0] span_q;
	logic [WORD_W-1:0] mix_q;
	logic              equal_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] result_q;
	logic [WORD_W-1:0] fold_operand;
	logic [WORD_W-1:0] fold_result;
	logic              fold_done;
	logic [WORD_W-1:0] rem_value;
	logic              rem_done;
	logic              accept;
	logic              bounds_equal;
	logic              out_free;
	logic              fold_start;
	logic              fold_sel_b;
	logic              rem_start;

	assign in_ready     = (state_q == S_IDLE);
	assign accept       = in_valid && in_ready;
	assign bounds_equal = (low_bound == high_bound);
	assign out_free     = !out_valid_q || out_ready;

	// Start the multiply passes and the remainder in turn
	assign fold_start = (accept && !bounds_equal) || ((state_q == S_MIX_A) && fold_done);
	assign fold_sel_b = (state_q == S_MIX_A);
	assign rem_start  = (state_q == S_MIX_B) && fold_done;

	// First pass mixes the counter, second pass mixes the first result
	assign fold_operand = (state_q == S_MIX_A) ? counter_q : mix_q;

	hcrr_fold u_fold (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (fold_ctl_q),
		.operand (fold_operand),
		.done    (fold_done),
		.result  (fold_result)
	);

	hcrr_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (rem_ctl_q),
		.dividend  (mix_q),
		.divisor   (span_q),
		.done      (rem_done),
		.remainder (rem_value)
	);

	// Sequencer: state, unit start requests, counter and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fold_ctl_q  <= '0;
			rem_ctl_q   <= '0;
			counter_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			fold_ctl_q <= '{start: fold_start, sel_b: fold_sel_b};
			rem_ctl_q  <= '{start: rem_start};
			// Load a finished item when the output is free, drop a taken one
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// Advance the counter for a draw, or reload it from the seed
			if (accept && !bounds_equal) begin
				counter_q <= counter_q + STEP_INCREMENT;
			end else if (seed_we) begin
				counter_q <= {{(WORD_W-32){seed_value[31]}}, seed_value};
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (bounds_equal) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_MIX_A;
						end
					end
				end
				S_MIX_A: begin
					if (fold_done) begin
						state_q <= S_MIX_B;
					end
				end
				S_MIX_B: begin
					if (fold_done) begin
						state_q <= S_REDUCE;
					end
				end
				S_REDUCE: begin
					if (rem_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture item fields and intermediate results
	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q    <= $unsigned(low_bound);
			span_q  <= $unsigned(high_bound) - $unsigned(low_bound) + 64'd1;
			equal_q <= bounds_equal;
		end
		if (fold_done) begin
			mix_q <= fold_result;
		end
		// Full-range span wraps to zero: add the raw mixed value unreduced
		if (state_q == S_DONE && out_free) begin
			if (equal_q) begin
				result_q <= '0;
			end else if (span_q == '0) begin
				result_q <= lo_q + mix_q;
			end else begin
				result_q <= lo_q + rem_value;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign random_value = $signed(result_q);

endmodule

>>> src/hcrr_fold.sv
// ----------------------------------------------------------------------------
// hcrr_fold
// Digit-serial multiply by a 32-bit mixing constant, low 64 bits kept, then
// xor with the product shifted right by 32. One 8-bit digit per cycle.
// ----------------------------------------------------------------------------
module hcrr_fold (
	input  logic                      clk,
	input  logic                      arst_n,
	input  hcrr_pkg::fold_ctl_t       ctl,
	input  logic [63:0]               operand,
	output logic                      done,
	output logic [63:0]               result
);
	import hcrr_pkg::*;

	logic [WORD_W-1:0]         mcand_q;
	logic [FACTOR_W-1:0]       mplier_q;
	logic [WORD_W-1:0]         acc_q;
	logic [DCNT_W-1:0]         cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [WORD_W+DIGIT_W-1:0] part_prod;

	// Partial product of the multiplicand and the current factor digit
	assign part_prod = {{DIGIT_W{1'b0}}, mcand_q} * {{WORD_W{1'b0}}, mplier_q[DIGIT_W-1:0]};

	// Control: start, count digits, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DCNT_W'(1);
				if (cnt_q == DCNT_W'(DIGITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load operands, then accumulate and shift one digit a cycle
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mcand_q  <= operand;
			mplier_q <= ctl.sel_b ? MIX_FACTOR_B : MIX_FACTOR_A;
			acc_q    <= '0;
		end else if (busy_q) begin
			acc_q    <= acc_q + part_prod[WORD_W-1:0];
			mcand_q  <= mcand_q << DIGIT_W;
			mplier_q <= mplier_q >> DIGIT_W;
		end
	end

	assign done   = done_q;
	assign result = acc_q ^ (acc_q >> SHIFT);

endmodule

>>> src/hcrr_rem.sv
// ----------------------------------------------------------------------------
// hcrr_rem
// Restoring bit-serial remainder of a 64-bit dividend by a 64-bit divisor,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module hcrr_rem (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hcrr_pkg::rem_ctl_t   ctl,
	input  logic [63:0]          dividend,
	input  logic [63:0]          divisor,
	output logic                 done,
	output logic [63:0]          remainder
);
	import hcrr_pkg::*;

	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] dvd_q;
	logic [WORD_W-1:0] div_q;
	logic [BCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [WORD_W:0]   trial;
	logic [WORD_W:0]   diff;

	// Shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, dvd_q[WORD_W-1]};
	assign diff  = trial - {1'b0, div_q};

	// Control: count dividend bits, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + BCNT_W'(1);
				if (cnt_q == BCNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: keep the difference when the trial value is not below the divisor
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (trial >= {1'b0, div_q}) begin
				rem_q <= diff[WORD_W-1:0];
			end else begin
				rem_q <= trial[WORD_W-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

>>> src/hcrr_checker.sv
// ----------------------------------------------------------------------------
// hcrr_port_checker
// Port-level checks on the hashed counter random range block, bound to the
// top level.
// ----------------------------------------------------------------------------
module hcrr_port_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               seed_we,
	input logic signed [31:0] seed_value,
	input logic               in_valid,
	input logic               in_ready,
	input logic signed [63:0] low_bound,
	input logic signed [63:0] high_bound,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [63:0] random_value
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(random_value))
		else $error("stalled result changed or dropped");

	// Take one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

	// Equal bounds give zero by way of the done state when the output is free
	a_equal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && low_bound == high_bound && (!out_valid || out_ready)
		|=> ##1 out_valid && random_value == 64'sd0)
		else $error("equal bounds did not give zero");

	// A mixed item cannot finish within the multiply passes
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && low_bound != high_bound && !out_valid
		|=> ##8 !out_valid)
		else $error("result appeared too early");

endmodule

bind hashed_counter_random_range hcrr_port_checker u_hcrr_checker (.*);

>>> bench/hcrr_checker.sv
// ----------------------------------------------------------------------------
// hcrr_checker
// Watches both channels and the seed port of the hashed counter random range
// block, keeps its own copy of the draw counter, works out the number due for
// every accepted request and compares it with each result that leaves.
// ----------------------------------------------------------------------------
module hcrr_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           seed_we,
	input  logic signed [31:0]             seed_value,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic signed [hcrr_pkg::WORD_W-1:0] low_bound,
	input  logic signed [hcrr_pkg::WORD_W-1:0] high_bound,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic signed [hcrr_pkg::WORD_W-1:0] random_value,
	output int                             mismatch_count,
	output int                             draws_outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] COUNTER_STEP = 64'h0000_0000_E120_FC15;
	localparam logic [31:0] FOLD_FACTOR_A = 32'h4A39_B70D;
	localparam logic [31:0] FOLD_FACTOR_B = 32'h12FA_D5C9;
	localparam int          FOLD_SHIFT    = 32;

	logic [63:0] draw_counter;
	logic [63:0] expected_draws [$];

	// Multiply by a 32-bit factor keeping the low 64 bits, then fold the top half in
	function automatic logic [63:0] fold(input logic [63:0] v, input logic [31:0] factor);
		logic [63:0] p;
		p = v * {32'd0, factor};
		return (p >> FOLD_SHIFT) ^ p;
	endfunction

	// Predict on request acceptance, compare on result acceptance
	always @(posedge clk or negedge arst_n) begin
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] span;
		logic [63:0] mixed;
		logic [63:0] want;
		if (!arst_n) begin
			draw_counter = '0;
			expected_draws.delete();
			draws_outstanding = 0;
			mismatch_count    = 0;
		end else begin
			// Seed write reloads the counter, sign-extended
			if (seed_we)
				draw_counter = {{32{seed_value[31]}}, seed_value};

			if (in_valid && in_ready) begin
				lo = low_bound;
				hi = high_bound;
				if (hi == lo) begin
					// Equal bounds: zero out, counter held
					want = '0;
				end else begin
					draw_counter = draw_counter + COUNTER_STEP;
					mixed = fold(fold(draw_counter, FOLD_FACTOR_A), FOLD_FACTOR_B);
					span  = hi + 64'd1 - lo;
					// A span that wraps to zero takes the raw mixed value
					if (span != 64'd0)
						mixed = mixed % span;
					want = lo + mixed;
				end
				expected_draws.push_back(want);
			end

			if (out_valid && out_ready) begin
				if (expected_draws.size() == 0) begin
					$error("random_value: no request outstanding, actual %h", random_value);
					mismatch_count++;
				end else begin
					want = expected_draws.pop_front();
					if (random_value !== want) begin
						$error("random_value: expected %h, actual %h", want, random_value);
						mismatch_count++;
					end
				end
			end
			draws_outstanding = expected_draws.size();
		end
	end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives range requests and seed writes into the hashed counter random range
// block under several idle and stall mixes, with a long output hold-off and
// a full drain, and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W             = hcrr_pkg::WORD_W;
	localparam int PHASE_ITEMS   = 350;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 90;
	localparam int QUIET_LIMIT   = 3000;

	localparam logic [63:0] MAX_S = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MIN_S = 64'h8000_0000_0000_0000;

	logic                clk;
	logic                arst_n;
	logic                seed_we;
	logic signed [31:0]  seed_value;
	logic                in_valid;
	logic                in_ready;
	logic signed [W-1:0] low_bound;
	logic signed [W-1:0] high_bound;
	logic                out_valid;
	logic                out_ready;
	logic signed [W-1:0] random_value;

	int mismatch_count;
	int draws_outstanding;

	int  idle_pct;
	int  stall_pct;
	bit  hold_start;
	bit  hold_taken;

	hashed_counter_random_range i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.seed_we      (seed_we),
		.seed_value   (seed_value),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.low_bound    (low_bound),
		.high_bound   (high_bound),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.random_value (random_value)
	);

	hcrr_checker i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.seed_we           (seed_we),
		.seed_value        (seed_value),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.low_bound         (low_bound),
		.high_bound        (high_bound),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.random_value      (random_value),
		.mismatch_count    (mismatch_count),
		.draws_outstanding (draws_outstanding)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Offer one item, idling first at the current rate, and hold until accepted
	task automatic offer_item(input logic [63:0] lo, input logic [63:0] hi);
		if (idle_pct > 0 && $urandom_range(99) < 10) begin
			// occasional long gap so it lands on varied points of the block's work
			in_valid <= 1'b0;
			repeat ($urandom_range(100, 1)) @(negedge clk);
		end else begin
			while ($urandom_range(99) < idle_pct) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid   <= 1'b1;
		low_bound  <= lo;
		high_bound <= hi;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Drop valid and wait until every result has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (draws_outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_seed(input logic [31:0] s);
		drain();
		seed_we    <= 1'b1;
		seed_value <= s;
		@(negedge clk);
		seed_we    <= 1'b0;
	endtask

	// Mix of request shapes with random content
	task automatic random_item();
		logic [63:0] lo;
		logic [63:0] hi;
		int kind;
		kind = $urandom_range(99);
		lo = rand64();
		if (kind < 30)
			hi = lo + 64'($urandom_range(1000));
		else if (kind < 40)
			hi = lo;
		else if (kind < 50)
			hi = lo - 64'd1;
		else if (kind < 60)
			hi = lo - 64'd2 - 64'($urandom_range(100000));
		else if (kind < 70)
			hi = lo + {32'd0, $urandom()};
		else
			hi = rand64();
		offer_item(lo, hi);
	endtask

	// Result side: random stalls, plus one long hold-off on request
	initial begin : receiver
		out_ready  = 1'b0;
		hold_taken = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_start && !hold_taken) begin
				hold_taken = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// End the run when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("testbench: done, errors");
		$finish;
	end

	initial begin : stimulus
		int ph;
		int n;
		arst_n     = 1'b0;
		seed_we    = 1'b0;
		seed_value = '0;
		in_valid   = 1'b0;
		low_bound  = '0;
		high_bound = '0;
		idle_pct   = 0;
		stall_pct  = 0;
		hold_start = 1'b0;

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: equal bounds, full-range wrap, low above high, extremes
		offer_item(64'd0, 64'd0);
		offer_item(MIN_S, MIN_S);
		offer_item(MAX_S, MAX_S);
		offer_item(64'd0, 64'd1);
		offer_item(MIN_S, MAX_S);
		offer_item(64'd0, '1);
		offer_item(64'd5, 64'd4);
		offer_item(MAX_S, MIN_S);
		offer_item(64'd10, 64'd3);
		offer_item(MIN_S, MIN_S + 64'd1);
		offer_item(MAX_S - 64'd1, MAX_S);
		offer_item(-64'sd10, 64'sd10);
		offer_item('1, 64'd0);
		offer_item(64'd0, MAX_S);
		offer_item(MIN_S, 64'd0);
		offer_item(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		offer_item(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		offer_item(64'd1, 64'd1);
		offer_item(64'd7, 64'd0);

		// Random phases, each under its own seed and handshake mix
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					load_seed(32'h8000_0000);
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					load_seed(32'h7FFF_FFFF);
					idle_pct  = 56;
					stall_pct = 0;
				end
				2: begin
					load_seed($urandom());
					idle_pct  = 0;
					stall_pct = 56;
				end
				default: begin
					load_seed(32'hFFFF_FFFF);
					idle_pct  = 25;
					stall_pct = 25;
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 0 && n == 100)
					hold_start = 1'b1;
				if (ph == 2 && n == 150)
					drain();
				random_item();
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && draws_outstanding == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
